// File: hdl/pfk_pkg.sv
// ----------------------------------------------------------------------------
// pfk_pkg
// Shared widths, types, constants and helpers for the arm kinematics pipeline.
// ----------------------------------------------------------------------------
package pfk_pkg;

    // Matrix entries, sines and cosines are Q2.30 in this many bits.
    localparam int MW = 34;
    // Width of a sum of two products, one bit wider than a product.
    localparam int PW = 2 * MW + 1;
    // CORDIC angle accumulator width (signed for rotation, low 32 bits wrap).
    localparam int ZW = 33;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    typedef logic signed [MW-1:0] ent_t;
    typedef logic signed [PW-1:0] wide_t;
    typedef ent_t [3:0] row_t;
    typedef row_t [2:0] mat_t;

    localparam ent_t CORDIC_GAIN = ent_t'(34'sh026DD3B6A);
    localparam ent_t Q_ONE       = ent_t'(34'sh040000000);
    localparam ent_t Q_HALF      = ent_t'(34'sh020000000);

    // Arctangent of 2^-k as a fraction of a turn, 2^32 per turn.
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Round a Q4.60 sum half up to Q2.30.
    function automatic ent_t rnd30(input wide_t v);
        wide_t s;
        s = (v + wide_t'(Q_HALF)) >>> 30;
        return s[MW-1:0];
    endfunction

    // Round a Q2.30 position half up to Q2.14 and saturate.
    function automatic logic [15:0] pos_round(input ent_t v);
        logic signed [MW:0] s;
        s = ($signed({v[MW-1], v}) + (MW+1)'(32768)) >>> 16;
        if (s > (MW+1)'(32767))
            return 16'h7FFF;
        else if (s < -(MW+1)'(32768))
            return 16'h8000;
        else
            return s[15:0];
    endfunction

endpackage

// File: hdl/prismatic_arm_forward_kinematics.sv
// One word per cycle is accepted while pose_stall is low; each accepted
// word gives one pose word.
// The chain is sine/cosine, four transform products, roll and yaw vectoring,
// roll sine/cosine, the pitch denominator and pitch vectoring, in that order.
// Stages hold their word under stall and take new ones into empty slots.
// Reset clears all valid flags and wrist_locked; data registers are not reset.
// ----------------------------------------------------------------------------
// prismatic_arm_forward_kinematics
// End position and roll, pitch, yaw of a six-joint arm with a sliding joint.
// ----------------------------------------------------------------------------
module prismatic_arm_forward_kinematics #(
    parameter int ANGLE_BITS    = pfk_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = pfk_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               joint_valid,
    output logic               joint_stall,
    input  logic [15:0]        waist_angle,
    input  logic [15:0]        shoulder_angle,
    input  logic [15:0]        slide_length,
    input  logic [15:0]        wrist_angle_a,
    input  logic [15:0]        wrist_angle_b,
    input  logic [15:0]        wrist_angle_c,
    output logic               pose_valid,
    input  logic               pose_stall,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic signed [15:0] roll,
    output logic signed [15:0] pitch,
    output logic signed [15:0] yaw
);

    localparam logic REG_WRIST_LOCKED = 1'b0;

    localparam int C      = CORDIC_STAGES;
    localparam int SC_END = C + 2;
    localparam int M1_END = C + 4;
    localparam int M2_END = C + 6;
    localparam int M3_END = C + 8;
    localparam int ACC    = C + 10;
    localparam int RZ     = ACC + C + 1;
    localparam int RS     = RZ + C + 2;
    localparam int DEN    = RS + 2;
    localparam int PZ     = DEN + C + 1;
    localparam int OUT    = PZ + 1;
    localparam int NST    = OUT + 1;
    localparam int MW     = pfk_pkg::MW;

    logic             wrist_locked_reg;
    logic [NST-1:0]   valid_reg;
    logic [NST:0]     adv;

    logic [15:0]      waist_reg;
    logic [15:0]      shoulder_reg;
    logic [15:0]      slide_reg;
    logic [15:0]      wa_reg;
    logic [15:0]      wb_reg;
    logic [15:0]      wc_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WRIST_LOCKED) ? {31'b0, wrist_locked_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wrist_locked_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr[2] == REG_WRIST_LOCKED)
            wrist_locked_reg <= pwdata[0];
    end

    // ------------------------------------------------------------------
    // Stage flow: a stage loads when it is empty or its word moves on.
    // ------------------------------------------------------------------
    assign adv[NST] = !pose_stall;

    for (genvar j = 0; j < NST; j++)
    begin : g_flow
        assign adv[j] = !valid_reg[j] || adv[j+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (adv[j])
                valid_reg[j] <= (j == 0) ? joint_valid : valid_reg[(j == 0) ? 0 : j-1];
        end
    end

    assign joint_stall = !adv[0];
    assign pose_valid  = valid_reg[OUT];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            waist_reg    <= waist_angle;
            shoulder_reg <= shoulder_angle;
            slide_reg    <= slide_length;
            wa_reg       <= wrist_locked_reg ? 16'h0 : wrist_angle_a;
            wb_reg       <= wrist_locked_reg ? 16'h0 : wrist_angle_b;
            wc_reg       <= wrist_locked_reg ? 16'h0 : wrist_angle_c;
        end
    end

    // ------------------------------------------------------------------
    // Joint sines and cosines
    // ------------------------------------------------------------------
    pfk_pkg::ent_t c0, s0, c1, s1, c3, s3, c4, s4, c5, s5;

    pfk_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(C)) u_sc_waist (
        .clk (clk), .en (adv[SC_END:1]), .ang ({waist_reg, 16'b0}), .co (c0), .si (s0)
    );
    pfk_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(C)) u_sc_shoulder (
        .clk (clk), .en (adv[SC_END:1]), .ang ({shoulder_reg, 16'b0}), .co (c1), .si (s1)
    );
    pfk_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(C)) u_sc_wrist_a (
        .clk (clk), .en (adv[SC_END:1]), .ang ({wa_reg, 16'b0}), .co (c3), .si (s3)
    );
    pfk_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(C)) u_sc_wrist_b (
        .clk (clk), .en (adv[SC_END:1]), .ang ({wb_reg, 16'b0}), .co (c4), .si (s4)
    );
    pfk_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(C)) u_sc_wrist_c (
        .clk (clk), .en (adv[SC_END:1]), .ang ({wc_reg, 16'b0}), .co (c5), .si (s5)
    );

    logic [2*MW-1:0] cs3_d, cs4_d, cs5_d;
    logic [15:0]     slide_d;

    pfk_delay #(.W(2*MW), .N(M1_END-SC_END)) u_dly_cs3 (
        .clk (clk), .en (adv[M1_END:SC_END+1]), .d ({c3, s3}), .q (cs3_d)
    );
    pfk_delay #(.W(2*MW), .N(M2_END-SC_END)) u_dly_cs4 (
        .clk (clk), .en (adv[M2_END:SC_END+1]), .d ({c4, s4}), .q (cs4_d)
    );
    pfk_delay #(.W(2*MW), .N(M3_END-SC_END)) u_dly_cs5 (
        .clk (clk), .en (adv[M3_END:SC_END+1]), .d ({c5, s5}), .q (cs5_d)
    );
    pfk_delay #(.W(16), .N(M1_END)) u_dly_slide (
        .clk (clk), .en (adv[M1_END:1]), .d (slide_reg), .q (slide_d)
    );

    // ------------------------------------------------------------------
    // Transform chain
    // ------------------------------------------------------------------
    pfk_pkg::mat_t acc0, acc1, acc2, acc3, acc4;
    pfk_pkg::ent_t tz_slide;

    always_comb
    begin
        acc0       = '0;
        acc0[0][0] = c0;
        acc0[0][2] = s0;
        acc0[1][0] = s0;
        acc0[1][2] = -c0;
        acc0[2][1] = pfk_pkg::Q_ONE;
    end

    assign tz_slide = pfk_pkg::ent_t'({slide_d, 14'b0});

    pfk_mat_step #(.TOOL(1'b0), .NEG(1'b1)) u_step_shoulder (
        .clk (clk), .en (adv[M1_END:SC_END+1]), .a (acc0),
        .co (c1), .si (s1), .tz (pfk_pkg::Q_HALF), .t (acc1)
    );
    pfk_mat_step #(.TOOL(1'b0), .NEG(1'b0)) u_step_wrist_a (
        .clk (clk), .en (adv[M2_END:M1_END+1]), .a (acc1),
        .co (pfk_pkg::ent_t'(cs3_d[2*MW-1:MW])), .si (pfk_pkg::ent_t'(cs3_d[MW-1:0])),
        .tz (tz_slide), .t (acc2)
    );
    pfk_mat_step #(.TOOL(1'b0), .NEG(1'b1)) u_step_wrist_b (
        .clk (clk), .en (adv[M3_END:M2_END+1]), .a (acc2),
        .co (pfk_pkg::ent_t'(cs4_d[2*MW-1:MW])), .si (pfk_pkg::ent_t'(cs4_d[MW-1:0])),
        .tz ('0), .t (acc3)
    );
    pfk_mat_step #(.TOOL(1'b1), .NEG(1'b0)) u_step_tool (
        .clk (clk), .en (adv[ACC:M3_END+1]), .a (acc3),
        .co (pfk_pkg::ent_t'(cs5_d[2*MW-1:MW])), .si (pfk_pkg::ent_t'(cs5_d[MW-1:0])),
        .tz ('0), .t (acc4)
    );

    // ------------------------------------------------------------------
    // Orientation
    // ------------------------------------------------------------------
    logic [31:0] zr, zy, zp, zr_d, zy_d;

    pfk_atan2 #(.CORDIC_STAGES(C)) u_at_roll (
        .clk (clk), .en (adv[RZ:ACC+1]), .y (acc4[0][1]), .x (acc4[0][0]), .z (zr)
    );
    pfk_atan2 #(.CORDIC_STAGES(C)) u_at_yaw (
        .clk (clk), .en (adv[RZ:ACC+1]), .y (acc4[1][2]), .x (acc4[2][2]), .z (zy)
    );

    pfk_pkg::ent_t cr, sr;

    pfk_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(C)) u_sc_roll (
        .clk (clk), .en (adv[RS:RZ+1]), .ang (zr), .co (cr), .si (sr)
    );

    logic [2*MW-1:0] a01_d;
    logic [MW-1:0]   a02_d;
    logic [3*MW-1:0] pos_d;

    pfk_delay #(.W(2*MW), .N(RS-ACC)) u_dly_a01 (
        .clk (clk), .en (adv[RS:ACC+1]), .d ({acc4[0][0], acc4[0][1]}), .q (a01_d)
    );
    pfk_delay #(.W(MW), .N(DEN-ACC)) u_dly_a02 (
        .clk (clk), .en (adv[DEN:ACC+1]), .d (acc4[0][2]), .q (a02_d)
    );
    pfk_delay #(.W(3*MW), .N(PZ-ACC)) u_dly_pos (
        .clk (clk), .en (adv[PZ:ACC+1]), .d ({acc4[0][3], acc4[1][3], acc4[2][3]}),
        .q (pos_d)
    );
    pfk_delay #(.W(64), .N(PZ-RZ)) u_dly_ry (
        .clk (clk), .en (adv[PZ:RZ+1]), .d ({zr, zy}), .q ({zr_d, zy_d})
    );

    // Pitch denominator: first row projected on the roll direction.
    logic signed [2*MW-1:0] dp0_reg, dp1_reg;
    pfk_pkg::ent_t          den_reg;
    pfk_pkg::ent_t          a00_v, a01_v, a02_neg;

    assign a00_v   = pfk_pkg::ent_t'(a01_d[2*MW-1:MW]);
    assign a01_v   = pfk_pkg::ent_t'(a01_d[MW-1:0]);
    assign a02_neg = -pfk_pkg::ent_t'(a02_d);

    always_ff @(posedge clk)
    begin
        if (adv[RS+1])
        begin
            dp0_reg <= a00_v * cr;
            dp1_reg <= a01_v * sr;
        end
        if (adv[DEN])
            den_reg <= pfk_pkg::rnd30(pfk_pkg::wide_t'(dp0_reg) + pfk_pkg::wide_t'(dp1_reg));
    end

    pfk_atan2 #(.CORDIC_STAGES(C)) u_at_pitch (
        .clk (clk), .en (adv[PZ:DEN+1]), .y (a02_neg), .x (den_reg), .z (zp)
    );

    // ------------------------------------------------------------------
    // Output word
    // ------------------------------------------------------------------
    logic [15:0] pos_x_reg, pos_y_reg, pos_z_reg, roll_reg, pitch_reg, yaw_reg;
    logic [31:0] zr_rnd, zp_rnd, zy_rnd;

    always_comb
    begin
        zr_rnd = zr_d + 32'h8000;
        zp_rnd = zp + 32'h8000;
        zy_rnd = zy_d + 32'h8000;
    end

    always_ff @(posedge clk)
    begin
        if (adv[OUT])
        begin
            pos_x_reg <= pfk_pkg::pos_round(pfk_pkg::ent_t'(pos_d[3*MW-1:2*MW]));
            pos_y_reg <= pfk_pkg::pos_round(pfk_pkg::ent_t'(pos_d[2*MW-1:MW]));
            pos_z_reg <= pfk_pkg::pos_round(pfk_pkg::ent_t'(pos_d[MW-1:0]));
            roll_reg  <= zr_rnd[31:16];
            pitch_reg <= zp_rnd[31:16];
            yaw_reg   <= zy_rnd[31:16];
        end
    end

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;
    assign roll  = roll_reg;
    assign pitch = pitch_reg;
    assign yaw   = yaw_reg;

endmodule

// File: hdl/pfk_cordic_cell.sv
// ----------------------------------------------------------------------------
// pfk_cordic_cell
// One CORDIC micro-rotation, in rotation or vectoring mode, with a side word.
// ----------------------------------------------------------------------------
module pfk_cordic_cell #(
    parameter int K      = 0,
    parameter bit VECTOR = 1'b0,
    parameter int SW     = 1
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [pfk_pkg::MW-1:0] x_d,
    input  logic signed [pfk_pkg::MW-1:0] y_d,
    input  logic signed [pfk_pkg::ZW-1:0] z_d,
    input  logic        [SW-1:0]          side_d,
    output logic signed [pfk_pkg::MW-1:0] x,
    output logic signed [pfk_pkg::MW-1:0] y,
    output logic signed [pfk_pkg::ZW-1:0] z,
    output logic        [SW-1:0]          side
);

    localparam logic signed [pfk_pkg::ZW-1:0] AT = {1'b0, pfk_pkg::ATAN_TURNS[K]};

    logic                          sub;
    logic signed [pfk_pkg::MW-1:0] xs;
    logic signed [pfk_pkg::MW-1:0] ys;
    logic signed [pfk_pkg::MW-1:0] x_next;
    logic signed [pfk_pkg::MW-1:0] y_next;
    logic signed [pfk_pkg::ZW-1:0] z_next;
    logic signed [pfk_pkg::MW-1:0] x_reg;
    logic signed [pfk_pkg::MW-1:0] y_reg;
    logic signed [pfk_pkg::ZW-1:0] z_reg;
    logic        [SW-1:0]          side_reg;

    // Rotation steers on the residual angle, vectoring on the sign of y.
    always_comb
    begin
        sub    = VECTOR ? y_d[pfk_pkg::MW-1] : !z_d[pfk_pkg::ZW-1];
        xs     = x_d >>> K;
        ys     = y_d >>> K;
        x_next = sub ? x_d - ys : x_d + ys;
        y_next = sub ? y_d + xs : y_d - xs;
        z_next = sub ? z_d - AT : z_d + AT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_d;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign side = side_reg;

endmodule

// File: hdl/pfk_delay.sv
// ----------------------------------------------------------------------------
// pfk_delay
// Shift line that keeps a word in step with the pipeline stages around it.
// ----------------------------------------------------------------------------
module pfk_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [N-1:0] en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [N+1];

    assign line_reg[0] = d;

    for (genvar i = 0; i < N; i++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (en[i])
                line_reg[i+1] <= line_reg[i];
        end
    end

    assign q = line_reg[N];

endmodule

// File: hdl/pfk_sincos.sv
// ----------------------------------------------------------------------------
// pfk_sincos
// Pipelined CORDIC sine and cosine of a turn angle, quadrant folded outside.
// ----------------------------------------------------------------------------
module pfk_sincos #(
    parameter int ANGLE_BITS    = pfk_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = pfk_pkg::CORDIC_STAGES_DEF
) (
    input  logic                   clk,
    input  logic [CORDIC_STAGES+1:0] en,
    input  logic [31:0]            ang,
    output pfk_pkg::ent_t          co,
    output pfk_pkg::ent_t          si
);

    localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

    logic [31:0]                   a;
    logic [31:0]                   a_off;
    logic [1:0]                    q_next;
    logic [31:0]                   r;
    logic signed [pfk_pkg::ZW-1:0] z_reg;
    logic [1:0]                    q_reg;
    pfk_pkg::ent_t                 co_reg;
    pfk_pkg::ent_t                 si_reg;

    logic signed [pfk_pkg::MW-1:0] xs [CORDIC_STAGES+1];
    logic signed [pfk_pkg::MW-1:0] ys [CORDIC_STAGES+1];
    logic signed [pfk_pkg::ZW-1:0] zs [CORDIC_STAGES+1];
    logic [1:0]                    qs [CORDIC_STAGES+1];

    always_comb
    begin
        a      = ang & PHASE_MASK;
        a_off  = a + 32'h2000_0000;
        q_next = a_off[31:30];
        r      = a - {q_next, 30'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z_reg <= {r[31], r};
            q_reg <= q_next;
        end
    end

    assign xs[0] = pfk_pkg::CORDIC_GAIN;
    assign ys[0] = '0;
    assign zs[0] = z_reg;
    assign qs[0] = q_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        pfk_cordic_cell #(
            .K      (i),
            .VECTOR (1'b0),
            .SW     (2)
        ) u_cell (
            .clk    (clk),
            .en     (en[i+1]),
            .x_d    (xs[i]),
            .y_d    (ys[i]),
            .z_d    (zs[i]),
            .side_d (qs[i]),
            .x      (xs[i+1]),
            .y      (ys[i+1]),
            .z      (zs[i+1]),
            .side   (qs[i+1])
        );
    end

    // The quadrant is put back by exact swaps and negations.
    always_ff @(posedge clk)
    begin
        if (en[CORDIC_STAGES+1])
        begin
            case (qs[CORDIC_STAGES])
                2'd0:
                begin
                    co_reg <= xs[CORDIC_STAGES];
                    si_reg <= ys[CORDIC_STAGES];
                end
                2'd1:
                begin
                    co_reg <= -ys[CORDIC_STAGES];
                    si_reg <= xs[CORDIC_STAGES];
                end
                2'd2:
                begin
                    co_reg <= -xs[CORDIC_STAGES];
                    si_reg <= -ys[CORDIC_STAGES];
                end
                default:
                begin
                    co_reg <= ys[CORDIC_STAGES];
                    si_reg <= -xs[CORDIC_STAGES];
                end
            endcase
        end
    end

    assign co = co_reg;
    assign si = si_reg;

endmodule

// File: hdl/pfk_atan2.sv
// ----------------------------------------------------------------------------
// pfk_atan2
// Pipelined CORDIC vectoring: angle of (x, y) as a 32-bit turn word.
// ----------------------------------------------------------------------------
module pfk_atan2 #(
    parameter int CORDIC_STAGES = pfk_pkg::CORDIC_STAGES_DEF
) (
    input  logic                   clk,
    input  logic [CORDIC_STAGES:0] en,
    input  pfk_pkg::ent_t          y,
    input  pfk_pkg::ent_t          x,
    output logic [31:0]            z
);

    logic signed [pfk_pkg::MW-1:0] x_reg;
    logic signed [pfk_pkg::MW-1:0] y_reg;
    logic signed [pfk_pkg::ZW-1:0] z_reg;
    logic                          zero_reg;

    logic signed [pfk_pkg::MW-1:0] xs [CORDIC_STAGES+1];
    logic signed [pfk_pkg::MW-1:0] ys [CORDIC_STAGES+1];
    logic signed [pfk_pkg::ZW-1:0] zs [CORDIC_STAGES+1];
    logic                          zf [CORDIC_STAGES+1];

    // A vector in the left half plane is turned by half a turn first.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            zero_reg <= (x == '0) && (y == '0);
            if (x[pfk_pkg::MW-1])
            begin
                x_reg <= -x;
                y_reg <= -y;
                z_reg <= pfk_pkg::ZW'(33'h0_8000_0000);
            end
            else
            begin
                x_reg <= x;
                y_reg <= y;
                z_reg <= '0;
            end
        end
    end

    assign xs[0] = x_reg;
    assign ys[0] = y_reg;
    assign zs[0] = z_reg;
    assign zf[0] = zero_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        pfk_cordic_cell #(
            .K      (i),
            .VECTOR (1'b1),
            .SW     (1)
        ) u_cell (
            .clk    (clk),
            .en     (en[i+1]),
            .x_d    (xs[i]),
            .y_d    (ys[i]),
            .z_d    (zs[i]),
            .side_d (zf[i]),
            .x      (xs[i+1]),
            .y      (ys[i+1]),
            .z      (zs[i+1]),
            .side   (zf[i+1])
        );
    end

    assign z = zf[CORDIC_STAGES] ? 32'h0 : zs[CORDIC_STAGES][31:0];

endmodule

// File: hdl/pfk_mat_step.sv
// ----------------------------------------------------------------------------
// pfk_mat_step
// Multiplies the running transform by one joint or tool plate transform.
// ----------------------------------------------------------------------------
module pfk_mat_step #(
    parameter bit TOOL = 1'b0,
    parameter bit NEG  = 1'b0
) (
    input  logic          clk,
    input  logic [1:0]    en,
    input  pfk_pkg::mat_t a,
    input  pfk_pkg::ent_t co,
    input  pfk_pkg::ent_t si,
    input  pfk_pkg::ent_t tz,
    output pfk_pkg::mat_t t
);

    typedef logic signed [2*pfk_pkg::MW-1:0] prod_t;

    pfk_pkg::mat_t t_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        pfk_pkg::ent_t a0;
        pfk_pkg::ent_t a1;
        pfk_pkg::ent_t a2;
        pfk_pkg::ent_t a3;
        prod_t         pac_reg;
        prod_t         pbs_reg;
        prod_t         pas_reg;
        prod_t         pbc_reg;
        prod_t         ptz_reg;
        pfk_pkg::ent_t a2_reg;
        pfk_pkg::ent_t a3_reg;
        pfk_pkg::wide_t s0;
        pfk_pkg::wide_t s1;
        pfk_pkg::wide_t s2;

        assign a0 = a[r][0];
        assign a1 = a[r][1];
        assign a2 = a[r][2];
        assign a3 = a[r][3];

        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                pac_reg <= a0 * co;
                pbs_reg <= a1 * si;
                pas_reg <= a0 * si;
                pbc_reg <= a1 * co;
                ptz_reg <= a2 * tz;
                a2_reg  <= a2;
                a3_reg  <= a3;
            end
        end

        always_comb
        begin
            s0 = pfk_pkg::wide_t'(pac_reg) + pfk_pkg::wide_t'(pbs_reg);
            s1 = pfk_pkg::wide_t'(pbc_reg) - pfk_pkg::wide_t'(pas_reg);
            s2 = pfk_pkg::wide_t'(pas_reg) - pfk_pkg::wide_t'(pbc_reg);
        end

        // Entries that meet an exact one or zero pass through unrounded.
        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                t_reg[r][0] <= pfk_pkg::rnd30(s0);
                if (TOOL)
                begin
                    t_reg[r][1] <= pfk_pkg::rnd30(s1);
                    t_reg[r][2] <= a2_reg;
                    t_reg[r][3] <= a3_reg;
                end
                else
                begin
                    t_reg[r][1] <= NEG ? -a2_reg : a2_reg;
                    t_reg[r][2] <= pfk_pkg::rnd30(NEG ? s1 : s2);
                    t_reg[r][3] <= a3_reg + pfk_pkg::rnd30(pfk_pkg::wide_t'(ptz_reg));
                end
            end
        end
    end

    assign t = t_reg;

endmodule
